// File: hdl/tppg_pkg.sv
// Shared types, constants and arithmetic helpers of the test pattern pixel generator.
`default_nettype none
package tppg_pkg;

    localparam int MAX_ITER = 16;
    localparam int ITER_W   = (MAX_ITER > 1) ? $clog2(MAX_ITER) : 1;
    localparam int DVD_W    = 44;
    localparam int DVS_W    = 27;
    localparam int Q_W      = 20;

    localparam logic [2:0] MODE_RAINBOW = 3'd0;
    localparam logic [2:0] MODE_GREY    = 3'd1;
    localparam logic [2:0] MODE_GRID    = 3'd2;
    localparam logic [2:0] MODE_NOISE   = 3'd3;
    localparam logic [2:0] MODE_HUENOIS = 3'd4;
    localparam logic [2:0] MODE_MANDEL  = 3'd5;
    localparam logic [2:0] MODE_CIRCLE  = 3'd6;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_XSPAN = 2'd1;
    localparam logic [1:0] CFG_YSPAN = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_DIV_U, OP_DIV_V, OP_DIV_HUE, OP_DIV_HN,
        OP_MUL_P, OP_MUL_D, OP_DIV_CX, OP_DIV_CY, OP_SQ_X, OP_SQ_Y,
        OP_MUL_XY, OP_UPD, OP_ESC, OP_INC, OP_FIN, OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic       div_done;
        logic       esc;
        logic       iter_last;
        logic       pix;
        logic       out_free;
    } t_stat;

    function automatic logic [16:0] hue_chan(input logic [18:0] h, input logic [2:0] off);
        logic [2:0]  off_n;
        logic [19:0] t;
        logic [19:0] d;
        logic [16:0] r;
        off_n = 3'd6 - off;
        t = {1'b0, h} + {1'b0, off_n, 16'b0};
        if (t >= 20'd393216) t = t - 20'd393216;
        if (t >= 20'd196608) d = t - 20'd196608;
        else d = 20'd196608 - t;
        if (d <= 20'd65536) r = 17'd0;
        else if (d >= 20'd131072) r = 17'h10000;
        else r = 17'(d - 20'd65536);
        return r;
    endfunction

    function automatic logic [7:0] to8(input logic [16:0] c);
        logic [24:0] p;
        p = {c, 8'b0} - {8'b0, c} + 25'd32768;
        return p[23:16];
    endfunction

    function automatic logic signed [19:0] sat_q(input logic signed [25:0] a);
        logic signed [19:0] r;
        if (a > 26'sd524287) r = 20'sh7FFFF;
        else if (a < -26'sd524288) r = 20'sh80000;
        else r = a[19:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hdl/tppg_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module tppg_div
    import tppg_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [DVD_W-1:0]      o_quo
);

    logic                     r_busy;
    logic                     r_done;
    logic [$clog2(DVD_W)-1:0] r_cnt;
    logic [DVS_W-1:0]         r_rem;
    logic [DVS_W-1:0]         r_dvs;
    logic [DVD_W-1:0]         r_quo;
    logic [DVS_W:0]           w_shift;
    logic [DVS_W:0]           w_diff;
    logic                     w_ge;

    assign w_shift = {r_rem, r_quo[DVD_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_dvs};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ($clog2(DVD_W))'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_shift[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
`default_nettype wire

// File: hdl/tppg_dp.sv
// Datapath: configuration, operand registers, shared multiplier and divider, output register.
`default_nettype none
module tppg_dp
    import tppg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [11:0] i_cfg_data,
    input  wire logic [55:0] i_s_data,
    input  wire logic        i_m_ready,
    output logic             o_m_valid,
    output logic [47:0]      o_m_data,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat
);

    logic [2:0]  r_mode;
    logic [11:0] r_xspan;
    logic [11:0] r_yspan;
    logic [11:0] r_x;
    logic [10:0] r_row;
    logic [15:0] r_rt;
    logic [15:0] r_rb;
    logic        r_pix;
    logic [27:0] r_u;
    logic [27:0] r_v;
    logic [18:0] r_h;
    logic signed [25:0] r_pnum;
    logic [23:0] r_den;
    logic        r_neg;
    t_op         r_dst;
    logic signed [19:0] r_cx;
    logic signed [19:0] r_cy;
    logic signed [19:0] r_zx;
    logic signed [19:0] r_zy;
    logic [38:0] r_a;
    logic [38:0] r_b;
    logic signed [23:0] r_c;
    logic [ITER_W-1:0] r_iter;
    logic        r_esc;
    logic [23:0] r_top;
    logic [23:0] r_bot;
    logic [47:0] r_odata;
    logic        r_ovalid;

    logic [11:0] w_w;
    logic [11:0] w_h;
    logic [11:0] w_y;
    logic [15:0] w_r;
    logic signed [14:0] w_dxw;
    logic signed [14:0] w_dyh;
    logic [14:0] w_dyh_abs;
    logic [25:0] w_pabs;
    logic [27:0] w_cx5;
    logic [16:0] w_cy5;
    logic [28:0] w_uv;
    logic [30:0] w_hue;
    logic [18:0] w_r6;
    logic [30:0] w_hq_p;
    logic [12:0] w_hq;
    logic [14:0] w_h6;
    logic [14:0] w_hrem;
    logic [16:0] w_r6lo;
    logic [2:0]  w_r6c;
    logic [18:0] w_hn;
    logic signed [20:0] w_ma;
    logic signed [20:0] w_mb;
    logic signed [41:0] w_prod;
    logic signed [25:0] w_sx;
    logic signed [25:0] w_sy;
    logic        w_esc;
    logic        w_inside;
    logic        w_start;
    logic [DVD_W-1:0] w_dvd;
    logic [DVS_W-1:0] w_dvs;
    logic        w_done;
    logic [DVD_W-1:0] w_quo;
    logic [16:0] w_grey;
    logic [16:0] w_noise;
    logic [16:0] w_flat;
    logic [ITER_W+4:0] w_i17;
    logic [7:0]  w_blue;
    logic [23:0] w_rgb;

    assign w_w = (r_xspan == 12'd0) ? 12'd1 : r_xspan;
    assign w_h = (r_yspan == 12'd0) ? 12'd1 : r_yspan;
    assign w_y = {r_row, r_pix};
    assign w_r = r_pix ? r_rb : r_rt;

    assign w_dxw     = $signed({2'b0, r_x, 1'b0}) - $signed({3'b0, w_w});
    assign w_dyh     = $signed({2'b0, w_y, 1'b0}) - $signed({3'b0, w_h});
    assign w_dyh_abs = w_dyh[14] ? 15'(-w_dyh) : 15'(w_dyh);
    assign w_pabs    = r_pnum[25] ? 26'(-r_pnum) : 26'(r_pnum);
    assign w_cx5     = {1'b0, w_pabs[24:0], 2'b0} + {3'b0, w_pabs[24:0]};
    assign w_cy5     = {1'b0, w_dyh_abs[13:0], 2'b0} + {3'b0, w_dyh_abs[13:0]};
    assign w_uv      = {1'b0, r_u} + {1'b0, r_v};
    assign w_hue     = {1'b0, w_uv, 1'b0} + {2'b0, w_uv};
    assign w_r6      = {1'b0, w_r, 2'b0} + {2'b0, w_r, 1'b0};

    // The integer part of the hue is reduced modulo six by a reciprocal multiplication.
    assign w_hq_p = {16'b0, w_hue[30:16]} * 31'd43691;
    assign w_hq   = w_hq_p[30:18];
    assign w_h6   = {w_hq, 2'b0} + {1'b0, w_hq, 1'b0};
    assign w_hrem = w_hue[30:16] - w_h6;

    // The noise hue is 6R + floor(6R / 65535), since 65536 / 65535 = 1 + 1 / 65535.
    assign w_r6lo = {1'b0, w_r6[15:0]} + {14'b0, w_r6[18:16]};
    assign w_r6c  = (w_r6lo >= 17'd65535) ? 3'(w_r6[18:16] + 3'd1) : w_r6[18:16];
    assign w_hn   = w_r6 + {16'b0, w_r6c};

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.op)
            OP_MUL_P: begin
                w_ma = {{6{w_dxw[14]}}, w_dxw};
                w_mb = {8'b0, 13'({1'b0, w_w} + 13'd1)};
            end
            OP_MUL_D: begin
                w_ma = {9'b0, w_w};
                w_mb = {8'b0, 13'({1'b0, w_h} + 13'd1)};
            end
            OP_SQ_X: begin
                w_ma = {r_zx[19], r_zx};
                w_mb = {r_zx[19], r_zx};
            end
            OP_SQ_Y: begin
                w_ma = {r_zy[19], r_zy};
                w_mb = {r_zy[19], r_zy};
            end
            OP_MUL_XY: begin
                w_ma = {r_zx[19], r_zx};
                w_mb = {r_zy[19], r_zy};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    always_comb begin
        w_start = 1'b1;
        w_dvd   = '0;
        w_dvs   = 27'd1;
        case (i_cmd.op)
            OP_DIV_U: begin
                w_dvd = {16'b0, r_x, 16'b0};
                w_dvs = {15'b0, w_w};
            end
            OP_DIV_V: begin
                w_dvd = {16'b0, w_y, 16'b0};
                w_dvs = {15'b0, w_h};
            end
            OP_DIV_CX: begin
                w_dvd = {w_cx5, 16'b0};
                w_dvs = {1'b0, r_den, 2'b0};
            end
            OP_DIV_CY: begin
                w_dvd = {11'b0, w_cy5, 16'b0};
                w_dvs = {13'b0, w_h, 2'b0};
            end
            default: begin
                w_start = 1'b0;
            end
        endcase
    end

    tppg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_done),
        .o_quo      (w_quo)
    );

    function automatic logic signed [19:0] sat_mag(input logic neg, input logic [DVD_W-1:0] m);
        logic signed [19:0] r;
        if (!neg) r = (m > 44'd524287) ? 20'sh7FFFF : $signed(m[19:0]);
        else r = (m > 44'd524288) ? 20'sh80000 : $signed(20'(-m[19:0]));
        return r;
    endfunction

    assign w_sx = $signed({3'b0, r_a[38:16]}) - $signed({3'b0, r_b[38:16]})
                + $signed({{6{r_cx[19]}}, r_cx});
    assign w_sy = $signed({r_c[23], r_c, 1'b0}) + $signed({{6{r_cy[19]}}, r_cy});
    assign w_esc    = ({1'b0, r_a[38:16]} + {1'b0, r_b[38:16]}) > 24'd262144;
    assign w_inside = ({1'b0, r_a} + {1'b0, r_b}) <= 40'h1_0000_0000;

    assign w_grey  = (w_uv[28:1] > 28'd65536) ? 17'h10000 : w_uv[17:1];
    assign w_noise = (w_r == 16'hFFFF) ? 17'h10000 : {1'b0, w_r};
    assign w_i17   = {1'b0, r_iter, 4'b0} + {5'b0, r_iter};
    assign w_blue  = (w_i17 >= (ITER_W+5)'(255)) ? 8'd255 : w_i17[7:0];

    always_comb begin
        w_flat = '0;
        w_rgb  = '0;
        case (r_mode) inside
            MODE_RAINBOW, MODE_HUENOIS: begin
                w_rgb = {to8(hue_chan(r_h, 3'd4)), to8(hue_chan(r_h, 3'd2)),
                         to8(hue_chan(r_h, 3'd0))};
            end
            MODE_GREY: begin
                w_flat = w_grey;
                w_rgb  = {3{to8(w_flat)}};
            end
            MODE_GRID: begin
                w_flat = (r_x[0] ^ r_pix) ? 17'd0 : 17'h10000;
                w_rgb  = {3{to8(w_flat)}};
            end
            MODE_NOISE: begin
                w_flat = w_noise;
                w_rgb  = {3{to8(w_flat)}};
            end
            MODE_MANDEL: begin
                w_rgb = {(r_esc ? w_blue : 8'd0), 16'd0};
            end
            MODE_CIRCLE: begin
                w_rgb = w_inside ? 24'hFFFFFF : 24'd0;
            end
            default: begin
                w_rgb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_RAINBOW;
            r_xspan  <= 12'd79;
            r_yspan  <= 12'd46;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_MODE:  r_mode  <= i_cfg_data[2:0];
                    CFG_XSPAN: r_xspan <= i_cfg_data;
                    CFG_YSPAN: r_yspan <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_OUT) r_ovalid <= 1'b1;
            else if (i_m_ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            case (r_dst)
                OP_DIV_U:   r_u <= w_quo[27:0];
                OP_DIV_V:   r_v <= w_quo[27:0];
                OP_DIV_CX: begin
                    r_cx <= sat_mag(r_neg, w_quo);
                    r_zx <= sat_mag(r_neg, w_quo);
                end
                OP_DIV_CY: begin
                    r_cy <= sat_mag(r_neg, w_quo);
                    r_zy <= sat_mag(r_neg, w_quo);
                end
                default: ;
            endcase
        end
        case (i_cmd.op) inside
            OP_LOAD: begin
                r_x   <= i_s_data[11:0];
                r_row <= i_s_data[22:12];
                r_rt  <= i_s_data[38:23];
                r_rb  <= i_s_data[54:39];
                r_pix <= 1'b0;
            end
            OP_DIV_U, OP_DIV_V: r_dst <= i_cmd.op;
            OP_DIV_HUE: r_h <= {w_hrem[2:0], w_hue[15:0]};
            OP_DIV_HN:  r_h <= (w_hn == 19'd393216) ? 19'd0 : w_hn;
            OP_DIV_CX: begin
                r_dst <= i_cmd.op;
                r_neg <= r_pnum[25];
            end
            OP_DIV_CY: begin
                r_dst <= i_cmd.op;
                r_neg <= w_dyh[14];
            end
            OP_MUL_P: begin
                r_pnum <= w_prod[25:0];
                r_iter <= '0;
                r_esc  <= 1'b0;
            end
            OP_MUL_D:  r_den <= w_prod[23:0];
            OP_SQ_X:   r_a   <= w_prod[38:0];
            OP_SQ_Y:   r_b   <= w_prod[38:0];
            OP_MUL_XY: r_c   <= w_prod[39:16];
            OP_UPD: begin
                r_zx <= sat_q(w_sx);
                r_zy <= sat_q(w_sy);
            end
            OP_ESC: r_esc  <= 1'b1;
            OP_INC: r_iter <= r_iter + 1'b1;
            OP_FIN: begin
                if (r_pix) r_bot <= w_rgb;
                else r_top <= w_rgb;
                r_pix <= ~r_pix;
            end
            OP_OUT: r_odata <= {r_bot, r_top};
            default: ;
        endcase
    end

    assign o_m_valid = r_ovalid;
    assign o_m_data  = r_odata;

    assign o_stat.mode      = r_mode;
    assign o_stat.div_done  = w_done;
    assign o_stat.esc       = w_esc;
    assign o_stat.iter_last = (r_iter == ITER_W'(MAX_ITER - 1));
    assign o_stat.pix       = r_pix;
    assign o_stat.out_free  = !r_ovalid || i_m_ready;

endmodule
`default_nettype wire

// File: hdl/tppg_ctrl.sv
// Controller state machine that sequences the datapath through each pixel.
`default_nettype none
module tppg_ctrl
    import tppg_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_s_valid,
    output logic       o_s_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [17:0] {
        S_IDLE  = 18'h00001,
        S_PIX   = 18'h00002,
        S_DU    = 18'h00004,
        S_DV    = 18'h00008,
        S_DH    = 18'h00010,
        S_DHN   = 18'h00020,
        S_MP    = 18'h00040,
        S_MD    = 18'h00080,
        S_DCX   = 18'h00100,
        S_DCY   = 18'h00200,
        S_SQX   = 18'h00400,
        S_SQY   = 18'h00800,
        S_CHK   = 18'h01000,
        S_MXY   = 18'h02000,
        S_UPD   = 18'h04000,
        S_FIN   = 18'h08000,
        S_OUT   = 18'h10000,
        S_DWAIT = 18'h20000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state r_ret;
    t_state n_ret;
    logic   r_loop;
    logic   n_loop;

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_loop    = r_loop;
        o_cmd.op  = OP_NONE;
        o_s_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_PIX;
                end
            end
            S_PIX: begin
                n_loop = 1'b0;
                case (i_stat.mode) inside
                    MODE_RAINBOW, MODE_GREY: n_state = S_DU;
                    MODE_HUENOIS:            n_state = S_DHN;
                    MODE_MANDEL, MODE_CIRCLE: n_state = S_MP;
                    default:                 n_state = S_FIN;
                endcase
            end
            S_DU: begin
                o_cmd.op = OP_DIV_U;
                n_ret    = S_DV;
                n_state  = S_DWAIT;
            end
            S_DV: begin
                o_cmd.op = OP_DIV_V;
                n_ret    = (i_stat.mode == MODE_RAINBOW) ? S_DH : S_FIN;
                n_state  = S_DWAIT;
            end
            S_DH: begin
                o_cmd.op = OP_DIV_HUE;
                n_state  = S_FIN;
            end
            S_DHN: begin
                o_cmd.op = OP_DIV_HN;
                n_state  = S_FIN;
            end
            S_MP: begin
                o_cmd.op = OP_MUL_P;
                n_state  = S_MD;
            end
            S_MD: begin
                o_cmd.op = OP_MUL_D;
                n_state  = S_DCX;
            end
            S_DCX: begin
                o_cmd.op = OP_DIV_CX;
                n_ret    = S_DCY;
                n_state  = S_DWAIT;
            end
            S_DCY: begin
                o_cmd.op = OP_DIV_CY;
                n_ret    = S_SQX;
                n_state  = S_DWAIT;
            end
            S_SQX: begin
                o_cmd.op = OP_SQ_X;
                n_state  = S_SQY;
            end
            S_SQY: begin
                o_cmd.op = OP_SQ_Y;
                if (i_stat.mode == MODE_CIRCLE) n_state = S_FIN;
                else if (r_loop) n_state = S_CHK;
                else n_state = S_MXY;
            end
            S_CHK: begin
                if (i_stat.esc) begin
                    o_cmd.op = OP_ESC;
                    n_state  = S_FIN;
                end else if (i_stat.iter_last) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.op = OP_INC;
                    n_state  = S_MXY;
                end
            end
            S_MXY: begin
                o_cmd.op = OP_MUL_XY;
                n_state  = S_UPD;
            end
            S_UPD: begin
                o_cmd.op = OP_UPD;
                n_loop   = 1'b1;
                n_state  = S_SQX;
            end
            S_FIN: begin
                o_cmd.op = OP_FIN;
                n_state  = i_stat.pix ? S_OUT : S_PIX;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            S_DWAIT: begin
                if (i_stat.div_done) n_state = r_ret;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_loop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_loop  <= n_loop;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DWAIT) && i_stat.div_done |=> r_state == $past(r_ret))
        else $error("divider wait did not return to the saved state");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_OUT) |-> i_stat.out_free)
        else $error("output register overwritten while a word is pending");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) && i_stat.esc |=> r_state == S_FIN)
        else $error("escape did not end the iteration");

endmodule
`default_nettype wire

// File: hdl/test_pattern_pixel_generator_core.sv
// Top level of the test pattern pixel generator: controller plus datapath.
//
//  Channel   Direction  Width  Contents
//  s_axis    in         56     character cell: column, row and two random samples
//  m_axis    out        48     top and bottom pixel, 8-bit RGB each
//  cfg       in         12     pattern mode, horizontal and vertical span
//
// One word is taken at a time; the next is accepted once the result moves to the output register.
// Each divider pass produces 44 quotient bits.
// Grid, noise and hue-noise words skip the divider; grey and rainbow pixels use the divider,
// circle and Mandelbrot pixels also the shared multiplier, which each Mandelbrot iteration uses for x*x, y*y and x*y.
// Reset is synchronous and active low; a stalled output holds the block in its output state.
`default_nettype none
module test_pattern_pixel_generator_core
    import tppg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [11:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // col_x[11:0], row_y[22:12], rand_top[38:23], rand_bottom[54:39], zero[55]
    input  wire logic [55:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // top_red[7:0], top_green[15:8], top_blue[23:16],
    // bottom_red[31:24], bottom_green[39:32], bottom_blue[47:40]
    output logic [47:0]      m_axis_tdata
);

    t_cmd  w_cmd;
    t_stat w_stat;

    tppg_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    tppg_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_data   (s_axis_tdata),
        .i_m_ready  (m_axis_tready),
        .o_m_valid  (m_axis_tvalid),
        .o_m_data   (m_axis_tdata),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat)
    );

endmodule
`default_nettype wire

// File: verif/test_pattern_pixel_generator_core_tb.sv
// Self-checking testbench of the test pattern pixel generator core.
`timescale 1ns / 100ps
`default_nettype none
module test_pattern_pixel_generator_core_tb;
    import tppg_pkg::*;

    localparam int NUM_RANDOM  = 1300;
    localparam int CYCLE_LIMIT = 2000000;
    localparam longint ONE  = 65536;
    localparam longint QMAX = 8 * 65536 - 1;
    localparam longint QMIN = -8 * 65536;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = CFG_MODE;
    logic [11:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    logic [2:0]  cur_mode;
    logic [11:0] cur_xspan;
    logic [11:0] cur_yspan;
    logic [55:0] cell_queue[$];
    logic [47:0] pixel_queue[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          src_gap = 0;
    int          snk_gap = 0;
    int          hold_cycles = 0;
    bit          quiet = 1'b0;
    bit          hold_sink = 1'b0;
    logic        s_fire = 1'b0;

    test_pattern_pixel_generator_core u_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint sat_coord(input longint a);
        if (a > QMAX) return QMAX;
        if (a < QMIN) return QMIN;
        return a;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        longint p;
        p = a * b;
        if (p >= 0) return p >>> 16;
        return -((-p + 65535) >>> 16);
    endfunction

    function automatic longint hue_level(input longint hue, input longint off);
        longint t;
        longint d;
        t = (hue + (6 - off) * ONE) % (6 * ONE);
        d = 3 * ONE - t;
        if (d < 0) d = -d;
        d -= ONE;
        if (d < 0) d = 0;
        if (d > ONE) d = ONE;
        return d;
    endfunction

    function automatic logic [7:0] chan_byte(input longint c);
        if (c < 0) c = 0;
        if (c > ONE) c = ONE;
        return 8'((c * 255 + 32768) >>> 16);
    endfunction

    function automatic logic [23:0] pixel_rgb(input longint x, input longint y,
                                              input longint w, input longint h,
                                              input longint r);
        longint u, v, cx, cy, zx, zy, tmp, g;
        longint c[3];
        u = (x * ONE) / w;
        v = (y * ONE) / h;
        c[0] = 0; c[1] = 0; c[2] = 0;
        case (cur_mode)
            MODE_RAINBOW: for (int k = 0; k < 3; k++) c[k] = hue_level(3 * (u + v), 2 * k);
            MODE_GREY: begin
                g = (u + v) >>> 1;
                c[0] = g; c[1] = g; c[2] = g;
            end
            MODE_GRID: begin
                g = ((x + y) % 2 == 0) ? ONE : 0;
                c[0] = g; c[1] = g; c[2] = g;
            end
            MODE_NOISE: begin
                g = (r * 65536) / 65535;
                c[0] = g; c[1] = g; c[2] = g;
            end
            MODE_HUENOIS: begin
                for (int k = 0; k < 3; k++)
                    c[k] = hue_level((r * 6 * 65536) / 65535, 2 * k);
            end
            MODE_MANDEL, MODE_CIRCLE: begin
                cx = sat_coord((5 * (2 * x - w) * (w + 1) * ONE) / (4 * w * (h + 1)));
                cy = sat_coord((5 * (2 * y - h) * ONE) / (4 * h));
                if (cur_mode == MODE_CIRCLE) begin
                    g = (cx * cx + cy * cy <= ONE * ONE) ? ONE : 0;
                    c[0] = g; c[1] = g; c[2] = g;
                end else begin
                    zx = cx;
                    zy = cy;
                    for (int i = 0; i < MAX_ITER; i++) begin
                        tmp = zx;
                        zx = sat_coord(qmul(zx, zx) - qmul(zy, zy) + cx);
                        zy = sat_coord(2 * qmul(tmp, zy) + cy);
                        if (qmul(zx, zx) + qmul(zy, zy) > 4 * ONE) begin
                            c[2] = (i * ONE) / 15;
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        return {chan_byte(c[2]), chan_byte(c[1]), chan_byte(c[0])};
    endfunction

    function automatic logic [47:0] cell_pixels(input logic [55:0] d);
        longint x, row, w, h;
        x = d[11:0];
        row = d[22:12];
        w = (cur_xspan == 0) ? 1 : cur_xspan;
        h = (cur_yspan == 0) ? 1 : cur_yspan;
        return {pixel_rgb(x, 2 * row + 1, w, h, d[54:39]),
                pixel_rgb(x, 2 * row, w, h, d[38:23])};
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR %s", msg);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        s_fire = s_axis_tvalid && s_axis_tready && i_rst_n;
        if (s_fire) begin
            pixel_queue.push_back(cell_pixels(s_axis_tdata));
            void'(cell_queue.pop_front());
        end
        if (m_axis_tvalid && m_axis_tready && i_rst_n) begin
            if (pixel_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", m_axis_tdata));
            end else begin
                logic [47:0] exp_pix;
                exp_pix = pixel_queue.pop_front();
                for (int k = 0; k < 6; k++)
                    if (m_axis_tdata[8*k +: 8] != exp_pix[8*k +: 8])
                        report_mismatch($sformatf("channel %0d got %h exp %h",
                                                  k, m_axis_tdata[8*k +: 8],
                                                  exp_pix[8*k +: 8]));
            end
        end
    end

    // Driver: presents queued cells, with random gaps between words.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !s_fire) begin
        end else if (src_gap > 0) begin
            src_gap <= src_gap - 1;
            s_axis_tvalid <= 1'b0;
        end else if (cell_queue.size() > 0) begin
            if (!quiet && !s_axis_tvalid && $urandom_range(0, 5) == 0) begin
                src_gap <= $urandom_range(0, 7);
                s_axis_tvalid <= 1'b0;
            end else begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= cell_queue[0];
            end
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_sink) begin
            m_axis_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap <= snk_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            snk_gap <= $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Length of the current receiver hold-off in cycles.
    always @(posedge i_clk) begin
        hold_cycles <= hold_sink ? hold_cycles + 1 : 0;
    end

    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MODE: cur_mode = val[2:0];
            CFG_XSPAN: cur_xspan = val;
            default: cur_yspan = val;
        endcase
    endtask

    task automatic drain();
        wait (cell_queue.size() == 0 && !s_axis_tvalid && pixel_queue.size() == 0);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic logic [55:0] make_cell(input logic [11:0] x, input logic [10:0] y,
                                              input logic [15:0] rt, input logic [15:0] rb);
        return {1'b0, rb, rt, y, x};
    endfunction

    function automatic logic [55:0] rand_cell(input int xs, input int ys);
        logic [11:0] x;
        logic [10:0] y;
        if ($urandom_range(0, 9) == 0) begin
            x = $urandom;
            y = $urandom;
        end else begin
            x = $urandom_range(0, xs);
            y = $urandom_range(0, (ys + 1) / 2);
        end
        return make_cell(x, y, $urandom, $urandom);
    endfunction

    initial begin
        logic [11:0] xs, ys;
        cur_mode = MODE_RAINBOW;
        cur_xspan = 79;
        cur_yspan = 46;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: reset spans, every mode, extremes, zero spans, unknown mode.
        for (int m = 0; m < 8; m++) begin
            write_reg(CFG_MODE, 12'(m));
            cell_queue.push_back(make_cell(0, 0, 0, 16'hFFFF));
            cell_queue.push_back(make_cell(79, 23, 16'hFFFF, 0));
            cell_queue.push_back(make_cell(12'hFFF, 11'h7FF, 16'h8000, 16'h7FFF));
            drain();
        end
        write_reg(CFG_XSPAN, 12'd0);
        write_reg(CFG_YSPAN, 12'd0);
        write_reg(CFG_MODE, 12'(MODE_GREY));
        cell_queue.push_back(make_cell(1, 0, 0, 0));
        drain();
        write_reg(CFG_MODE, 12'(MODE_CIRCLE));
        cell_queue.push_back(make_cell(1, 0, 0, 0));
        drain();
        write_reg(CFG_XSPAN, 12'hFFF);
        write_reg(CFG_YSPAN, 12'hFFF);
        cell_queue.push_back(make_cell(12'hFFF, 11'h7FF, 0, 0));
        cell_queue.push_back(make_cell(2048, 1024, 0, 0));
        drain();
        // Long receiver hold-off while the sender keeps offering.
        write_reg(CFG_MODE, 12'(MODE_GRID));
        hold_sink = 1'b1;
        for (int i = 0; i < 6; i++) cell_queue.push_back(rand_cell(4095, 4095));
        wait (hold_cycles >= 300);
        @(negedge i_clk);
        hold_sink = 1'b0;
        drain();
        // Random phases with varied settings.
        for (int ph = 0; ph < 13; ph++) begin
            xs = (ph % 4 == 0) ? 12'(1 + $urandom_range(0, 1) * 4094) : 12'($urandom_range(1, 200));
            ys = (ph % 5 == 0) ? 12'(1 + $urandom_range(0, 1) * 4094) : 12'($urandom_range(1, 120));
            write_reg(CFG_XSPAN, xs);
            write_reg(CFG_YSPAN, ys);
            write_reg(CFG_MODE, 12'($urandom_range(0, 7)));
            if (ph == 12) quiet = 1'b1;
            for (int i = 0; i < NUM_RANDOM / 13; i++) cell_queue.push_back(rand_cell(xs, ys));
            drain();
        end
        repeat (50) @(negedge i_clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire
